// ===== src/rsha_pkg.sv =====
package rsha_pkg;

    localparam int WORD_BITS  = 4;
    localparam int ROUNDS     = 7;
    localparam int REGS       = 8;
    localparam int PRIOR_BITS = 28;

    typedef logic [WORD_BITS-1:0]       t_word;
    typedef t_word [REGS-1:0]           t_regs;
    typedef t_word [ROUNDS-1:0]         t_sched;

    typedef struct packed {
        t_regs  regs;
        t_sched w;
    } t_msg;

    typedef t_msg [1:0] t_stage;

    typedef enum logic [1:0] {
        CFG_FIRST_START  = 2'd0,
        CFG_SECOND_START = 2'd1,
        CFG_FIRST_PRIOR  = 2'd2,
        CFG_SECOND_PRIOR = 2'd3
    } t_cfg_index;

    // low nibbles of K[57..63]
    localparam t_word ROUND_K [ROUNDS] = '{
        4'hf, 4'h4, 4'h8, 4'ha, 4'hb, 4'h7, 4'h2
    };

    function automatic t_word rotr(t_word x, int k);
        return t_word'((x >> k) | (x << (WORD_BITS - k)));
    endfunction

    function automatic t_word big_sig0(t_word x);
        return rotr(x, 1) ^ rotr(x, 2) ^ rotr(x, 3);
    endfunction

    // rotr1 ^ rotr1 cancels, leaving rotr3
    function automatic t_word big_sig1(t_word x);
        return rotr(x, 3);
    endfunction

    function automatic t_word small_sig0(t_word x);
        return rotr(x, 1) ^ rotr(x, 2) ^ (x >> 1);
    endfunction

    function automatic t_word small_sig1(t_word x);
        return x >> 1;
    endfunction

    // prior nibbles: 0=W45 1=W46 2=W47 3=W48 4=W54 5=W55 6=W56
    function automatic t_sched expand(t_sched prior, logic [4*WORD_BITS-1:0] free_w);
        t_sched w;
        for (int i = 0; i < 4; i++) begin
            w[i] = free_w[i*WORD_BITS +: WORD_BITS];
        end
        w[4] = small_sig1(w[2]) + prior[4] + small_sig0(prior[1]) + prior[0];
        w[5] = small_sig1(w[3]) + prior[5] + small_sig0(prior[2]) + prior[1];
        w[6] = small_sig1(w[4]) + prior[6] + small_sig0(prior[3]) + prior[2];
        w[ROUNDS-1] = w[6];
        return w;
    endfunction

    function automatic t_regs round_fn(t_regs r, t_word k, t_word w);
        t_regs q;
        t_word t1;
        t_word t2;
        t_word ch;
        t_word mj;
        ch = (r[4] & r[5]) ^ (~r[4] & r[6]);
        mj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
        t1 = r[7] + big_sig1(r[4]) + ch + k + w;
        t2 = big_sig0(r[0]) + mj;
        q[7] = r[6];
        q[6] = r[5];
        q[5] = r[4];
        q[4] = r[3] + t1;
        q[3] = r[2];
        q[2] = r[1];
        q[1] = r[0];
        q[0] = t1 + t2;
        return q;
    endfunction

endpackage

// ===== src/reduced_sha256_tail_difference_unit.sv =====
// Reduced-width SHA-256 tail difference. Each input transfer carries the
// four free schedule words (57..60) of two messages; the unit extends both
// schedules to word 63, runs rounds 57..63 at 4-bit width from the
// configured start states and returns the XOR of the two final register
// sets a..h. One item is accepted per clock while the output is not stalled.
// One stage builds the schedules, six stages each run one round, and the
// output register runs the last round and forms the difference. Each stage
// holds its item while the next one cannot take it, so bubbles are squeezed out
// during output stalls. Configuration is written through a separate channel
// that is always ready and must only be used while no item is in flight.
module reduced_sha256_tail_difference_unit
    import rsha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // free_words[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // register_difference[31:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int STAGES = ROUNDS;   // stage 0 schedule, stages 1..6 rounds

    logic [31:0]           r_start [2];
    logic [PRIOR_BITS-1:0] r_prior [2];

    logic [STAGES-1:0] r_v;
    t_stage            r_st  [STAGES];
    t_stage            n_st  [STAGES];
    logic [STAGES:0]   w_rdy;

    logic        r_out_v;
    logic [31:0] r_out_diff;
    logic [31:0] n_out_diff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start[0] <= '0;
            r_start[1] <= '0;
            r_prior[0] <= '0;
            r_prior[1] <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FIRST_START:  r_start[0] <= i_cfg_data;
                CFG_SECOND_START: r_start[1] <= i_cfg_data;
                CFG_FIRST_PRIOR:  r_prior[0] <= i_cfg_data[PRIOR_BITS-1:0];
                CFG_SECOND_PRIOR: r_prior[1] <= i_cfg_data[PRIOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // a stage may load when empty or when its content moves on
    always_comb begin
        w_rdy[STAGES] = !r_out_v || m_axis_tready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            w_rdy[i] = !r_v[i] || w_rdy[i+1];
        end
    end
    assign s_axis_tready = w_rdy[0];

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            n_st[0][m].w    = expand(t_sched'(r_prior[m]), s_axis_tdata[16*m +: 16]);
            n_st[0][m].regs = t_regs'(r_start[m]);
        end
        for (int i = 1; i < STAGES; i++) begin
            for (int m = 0; m < 2; m++) begin
                n_st[i][m].w    = r_st[i-1][m].w;
                n_st[i][m].regs = round_fn(r_st[i-1][m].regs, ROUND_K[i-1],
                                           r_st[i-1][m].w[i-1]);
            end
        end
    end

    always_comb begin
        t_regs fin0;
        t_regs fin1;
        fin0 = round_fn(r_st[STAGES-1][0].regs, ROUND_K[ROUNDS-1],
                        r_st[STAGES-1][0].w[ROUNDS-1]);
        fin1 = round_fn(r_st[STAGES-1][1].regs, ROUND_K[ROUNDS-1],
                        r_st[STAGES-1][1].w[ROUNDS-1]);
        n_out_diff = 32'(fin0 ^ fin1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (w_rdy[0]) r_v[0] <= s_axis_tvalid;
            for (int i = 1; i < STAGES; i++) begin
                if (w_rdy[i]) r_v[i] <= r_v[i-1];
            end
            if (w_rdy[STAGES]) r_out_v <= r_v[STAGES-1];
        end
    end

    // payload: load only on a real transfer into the stage
    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && s_axis_tvalid) r_st[0] <= n_st[0];
        for (int i = 1; i < STAGES; i++) begin
            if (w_rdy[i] && r_v[i-1]) r_st[i] <= n_st[i];
        end
        if (w_rdy[STAGES] && r_v[STAGES-1]) r_out_diff <= n_out_diff;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_diff;

`ifndef SYNTHESIS
    a_empty_head_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> s_axis_tready)
        else $error("input not ready with empty first stage");

    a_accept_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v[0])
        else $error("accepted transfer not held in first stage");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !w_rdy[1] |=> r_v[0] && $stable(r_st[0]))
        else $error("stalled first stage lost its item");

    a_tail_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[STAGES-1] && w_rdy[STAGES] |=> m_axis_tvalid)
        else $error("last stage item did not reach the output");
`endif

endmodule

// ===== verif/reduced_sha256_tail_difference_checker.sv =====
module reduced_sha256_tail_difference_checker
    import rsha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,    // free_words[31:0]
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // register_difference[31:0]
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_failures,
    output int          o_pending,
    output int          o_checked
);

    localparam int TAIL_ROUNDS = 7;
    localparam int PRIOR_WORDS = 7;
    localparam int STATE_WORDS = 8;

    // full SHA-256 K[57..63]; only the low nibble takes part at this width
    localparam logic [31:0] TAIL_K [TAIL_ROUNDS] = '{
        32'h78a5636f, 32'h84c87814, 32'h8cc70208, 32'h90befffa,
        32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0] first_start;
    logic [31:0] second_start;
    logic [27:0] first_prior;
    logic [27:0] second_prior;
    logic [31:0] due_differences [$];
    logic [31:0] want;

    function automatic t_word rot_right(t_word x, int unsigned k);
        logic [2*WORD_BITS-1:0] twice;
        twice = {x, x};
        return twice[k +: WORD_BITS];
    endfunction

    function automatic t_word sum_a(t_word x);
        return rot_right(x, 1) ^ rot_right(x, 2) ^ rot_right(x, 3);
    endfunction

    function automatic t_word sum_e(t_word x);
        return rot_right(x, 1) ^ rot_right(x, 1) ^ rot_right(x, 3);
    endfunction

    function automatic t_word mix_low(t_word x);
        return rot_right(x, 1) ^ rot_right(x, 2) ^ (x >> 1);
    endfunction

    function automatic t_word mix_high(t_word x);
        return rot_right(x, 2) ^ rot_right(x, 2) ^ (x >> 1);
    endfunction

    // One message: extend the schedule to word 63, run rounds 57..63 and
    // return the final a..h, one nibble each, a lowest.
    function automatic logic [31:0] tail_registers(logic [31:0] start,
                                                   logic [27:0] prior,
                                                   logic [15:0] free_w);
        t_word       sched [TAIL_ROUNDS];
        t_word       hist  [PRIOR_WORDS];
        t_word       r     [STATE_WORDS];
        t_word       t1;
        t_word       t2;
        t_word       ch;
        t_word       mj;
        logic [31:0] regs_out;
        // hist holds W45, W46, W47, W48, W54, W55, W56
        for (int n = 0; n < PRIOR_WORDS; n++) begin
            hist[n] = prior[WORD_BITS*n +: WORD_BITS];
        end
        for (int n = 0; n < 4; n++) begin
            sched[n] = free_w[WORD_BITS*n +: WORD_BITS];
        end
        sched[4] = mix_high(sched[2]) + hist[4] + mix_low(hist[1]) + hist[0];
        sched[5] = mix_high(sched[3]) + hist[5] + mix_low(hist[2]) + hist[1];
        sched[6] = mix_high(sched[4]) + hist[6] + mix_low(hist[3]) + hist[2];
        for (int n = 0; n < STATE_WORDS; n++) begin
            r[n] = start[WORD_BITS*n +: WORD_BITS];
        end
        for (int n = 0; n < TAIL_ROUNDS; n++) begin
            ch = (r[4] & r[5]) ^ (~r[4] & r[6]);
            mj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
            t1 = r[7] + sum_e(r[4]) + ch + t_word'(TAIL_K[n]) + sched[n];
            t2 = sum_a(r[0]) + mj;
            r[7] = r[6];
            r[6] = r[5];
            r[5] = r[4];
            r[4] = r[3] + t1;
            r[3] = r[2];
            r[2] = r[1];
            r[1] = r[0];
            r[0] = t1 + t2;
        end
        for (int n = 0; n < STATE_WORDS; n++) begin
            regs_out[WORD_BITS*n +: WORD_BITS] = r[n];
        end
        return regs_out;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            first_start  <= '0;
            second_start <= '0;
            first_prior  <= '0;
            second_prior <= '0;
            due_differences.delete();
            o_failures <= 0;
            o_pending  <= 0;
            o_checked  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_FIRST_START:  first_start  <= i_cfg_data;
                    CFG_SECOND_START: second_start <= i_cfg_data;
                    CFG_FIRST_PRIOR:  first_prior  <= i_cfg_data[27:0];
                    CFG_SECOND_PRIOR: second_prior <= i_cfg_data[27:0];
                    default: ;
                endcase
            end
            // compare before queueing so a fresh item can never match itself
            if (i_out_valid && i_out_ready) begin
                if (due_differences.size() == 0) begin
                    $error("register_difference: unexpected transfer, actual %08h",
                           i_out_data);
                    o_failures <= o_failures + 1;
                end else begin
                    want = due_differences.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_out_data !== want) begin
                        $error("register_difference mismatch: expected %08h, actual %08h",
                               want, i_out_data);
                        o_failures <= o_failures + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                due_differences.push_back(
                    tail_registers(first_start, first_prior, i_in_data[15:0]) ^
                    tail_registers(second_start, second_prior, i_in_data[31:16]));
            end
            o_pending <= due_differences.size();
        end
    end

endmodule

// ===== verif/reduced_sha256_tail_difference_unit_tb.sv =====
module reduced_sha256_tail_difference_unit_tb;
    import rsha_pkg::*;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_COMB,
        SINK_SLOW
    } t_sink_mode;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 135;
    localparam int EDGE_COUNT    = 8;

    localparam logic [31:0] EDGE_WORDS [EDGE_COUNT] = '{
        32'h00000000, 32'hffffffff, 32'h0000ffff, 32'hffff0000,
        32'h0f0f0f0f, 32'hf0f0f0f0, 32'h12341234, 32'h84218420
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;

    int          cycle_count   = 0;
    int          burst_left    = 0;
    int          items_sent    = 0;
    int          settings_used = 1;
    int          sink_cycle    = 0;
    t_sink_mode  sink_mode     = SINK_OPEN;
    int          failures;
    int          pending;
    int          checked;
    logic [31:0] fs;
    logic [31:0] ss;
    logic [31:0] fp;
    logic [31:0] sp;

    reduced_sha256_tail_difference_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    reduced_sha256_tail_difference_checker u_diff_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: repeatedly redraw a random stall pattern
    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        if (sink_cycle % 200 == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
        end
        case (sink_mode)
            SINK_OPEN: m_axis_tready <= 1'b1;
            SINK_COIN: m_axis_tready <= ($urandom_range(0, 1) == 0);
            SINK_COMB: m_axis_tready <= (sink_cycle % 7) >= 3;
            default: begin
                if ($urandom_range(0, 11) == 0) begin
                    m_axis_tready <= !m_axis_tready;
                end
            end
        endcase
    end

    function automatic logic [31:0] pick_setting();
        case ($urandom_range(0, 5))
            0: return 32'h00000000;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] draw_free_words();
        logic [15:0] half;
        logic [31:0] value;
        half = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: value = $urandom;
            // equal halves: both messages share the free words
            4, 5: value = {half, half};
            6: value = {half ^ 16'(1 << $urandom_range(0, 15)), half};
            7: begin
                for (int n = 0; n < 8; n++) begin
                    value[4*n +: 4] = ($urandom_range(0, 1) != 0) ? 4'hf : 4'h0;
                end
            end
            default: value = $urandom & $urandom;
        endcase
        return value;
    endfunction

    // hold valid across back-to-back transfers; drop it only for a gap
    task automatic send_free_words(input logic [31:0] value);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input logic [31:0] first_start,
                                  input logic [31:0] second_start,
                                  input logic [31:0] first_prior,
                                  input logic [31:0] second_prior);
        write_register(CFG_FIRST_START, first_start);
        write_register(CFG_SECOND_START, second_start);
        write_register(CFG_FIRST_PRIOR, first_prior);
        write_register(CFG_SECOND_PRIOR, second_prior);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // wait until the pipeline is empty before touching the registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (EDGE_WORDS[n]) send_free_words(EDGE_WORDS[n]);
        drain();
        apply_settings(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        foreach (EDGE_WORDS[n]) send_free_words(EDGE_WORDS[n]);
        drain();
        // same message setup once the top nibble of the prior words is dropped
        apply_settings(32'h89abcdef, 32'h89abcdef, 32'hf7654321, 32'h07654321);
        foreach (EDGE_WORDS[n]) send_free_words(EDGE_WORDS[n]);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            fs = pick_setting();
            ss = ($urandom_range(0, 3) == 0) ? fs : pick_setting();
            fp = pick_setting();
            sp = ($urandom_range(0, 3) == 0) ? fp ^ {4'($urandom_range(0, 15)), 28'h0}
                                             : pick_setting();
            apply_settings(fs, ss, fp, sp);
            repeat (PHASE_ITEMS) send_free_words(draw_free_words());
            drain();
        end

        $display("sent %0d free-word transfers under %0d register settings",
                 items_sent, settings_used);
        $display("compared %0d register differences against the prediction", checked);
        if (failures == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/rsha_pkg.sv
src/reduced_sha256_tail_difference_unit.sv
verif/reduced_sha256_tail_difference_checker.sv
verif/reduced_sha256_tail_difference_unit_tb.sv
